[rtl/pta_pkg.sv]
// ----------------------------------------------------------------------------
// pta_pkg
// Shared widths, constants, types and the emphasis factor lookup for the
// pixel tint adjust pipeline.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned BrightW = 12;
  localparam int unsigned FlagW   = 8;
  localparam int unsigned PixW    = 32;
  localparam int unsigned FactorW = 11;
  localparam int unsigned Stages  = 5;

  localparam int unsigned FlagGray   = 0;
  localparam int unsigned FlagEmphLo = 5;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // floor(s / 3) = (s * 683) >> 11 for s <= 765
  localparam logic [9:0]  Div3Mul      = 10'd683;
  localparam int unsigned Div3Shift    = 11;
  // floor(x / 1000) = (x * 536871) >> 29 for x < 2**19
  localparam logic [19:0] Div1000Mul   = 20'd536871;
  localparam int unsigned Div1000Shift = 29;

  // factor after truncating 11/10 and 9/10 steps from 1000
  localparam logic [FactorW-1:0] FactorBase  = 11'd1000;
  localparam logic [FactorW-1:0] FactorD     = 11'd900;
  localparam logic [FactorW-1:0] FactorDD    = 11'd810;
  localparam logic [FactorW-1:0] FactorU     = 11'd1100;
  localparam logic [FactorW-1:0] FactorUD    = 11'd990;
  localparam logic [FactorW-1:0] FactorUDD   = 11'd891;

  // index 2 is red, 1 green, 0 blue, so the vector packs as in ARGB
  typedef logic [NumChan-1:0][ChanW-1:0]   chan_vec_t;
  typedef logic [NumChan-1:0][FactorW-1:0] factor_vec_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } lane_en_t;

  // The truncated steps commute for these ratios, so only the own bit and
  // the number of other set bits matter.
  function automatic logic [FactorW-1:0] emph_factor(logic own, logic [1:0] n_other);
    logic [FactorW-1:0] f;
    case ({own, n_other})
      3'b000:  f = FactorBase;
      3'b001:  f = FactorD;
      3'b010:  f = FactorDD;
      3'b100:  f = FactorU;
      3'b101:  f = FactorUD;
      3'b110:  f = FactorUDD;
      default: f = FactorBase;
    endcase
    return f;
  endfunction

endpackage

[rtl/pta_chan_lane.sv]
// ----------------------------------------------------------------------------
// pta_chan_lane
// One color channel: alpha premultiply, then brightness scale with
// saturation. Two register stages.
// ----------------------------------------------------------------------------
module pta_chan_lane (
  input  logic                          clk_i,
  input  pta_pkg::lane_en_t             en_i,
  input  logic [pta_pkg::ChanW-1:0]     alpha_i,
  input  logic [pta_pkg::ChanW-1:0]     chan_i,
  input  logic [pta_pkg::BrightW-1:0]   bright_i,
  output logic [pta_pkg::ChanW-1:0]     chan_o
);
  import pta_pkg::*;

  logic [ChanW:0]           alpha_p1;
  logic [2*ChanW:0]         premul;
  logic [ChanW-1:0]         c1_d, c1_q;
  logic [ChanW:0]           c1_p1;
  logic [BrightW+ChanW:0]   bprod;
  logic [BrightW:0]         bscaled;
  logic [ChanW-1:0]         c2_d, c2_q;

  // alpha 255 gives (256 * c) >> 8 = c, so no bypass is needed
  assign alpha_p1 = {1'b0, alpha_i} + (ChanW+1)'(1);
  assign premul   = alpha_p1 * chan_i;
  assign c1_d     = premul[2*ChanW-1:ChanW];

  // brightness 255 gives (255 * (c + 1)) >> 8 = c as well
  assign c1_p1   = {1'b0, c1_q} + (ChanW+1)'(1);
  assign bprod   = bright_i * c1_p1;
  assign bscaled = bprod[BrightW+ChanW:ChanW];
  assign c2_d    = (bscaled > (BrightW+1)'(ChanMax)) ? ChanMax : bscaled[ChanW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.load_a) begin
      c1_q <= c1_d;
    end
    if (en_i.load_b) begin
      c2_q <= c2_d;
    end
  end

  assign chan_o = c2_q;

endmodule

[rtl/pta_gray_merge.sv]
// ----------------------------------------------------------------------------
// pta_gray_merge
// Merges the three channel lanes: optional grayscale average, and the
// per-channel emphasis factors from the flag bits. One register stage.
// ----------------------------------------------------------------------------
module pta_gray_merge (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  pta_pkg::chan_vec_t          chan_i,
  input  logic [pta_pkg::FlagW-1:0]   flags_i,
  output pta_pkg::chan_vec_t          chan_o,
  output pta_pkg::factor_vec_t        factor_o
);
  import pta_pkg::*;

  logic [ChanW+1:0]         sum;
  logic [2*(ChanW+2)-1:0]   avg_prod;
  logic [ChanW-1:0]         avg;
  logic [NumChan-1:0]       mask;
  chan_vec_t                chan_d, chan_q;
  factor_vec_t              factor_d, factor_q;

  assign sum      = (ChanW+2)'(chan_i[0]) + (ChanW+2)'(chan_i[1]) + (ChanW+2)'(chan_i[2]);
  assign avg_prod = sum * Div3Mul;
  assign avg      = avg_prod[Div3Shift +: ChanW];

  // mask bit 0 is red
  assign mask = flags_i[FlagEmphLo +: NumChan];

  for (genvar k = 0; k < NumChan; k++) begin : g_ch
    logic       own;
    logic [1:0] n_other;

    assign own     = mask[NumChan-1-k];
    assign n_other = 2'(mask[0]) + 2'(mask[1]) + 2'(mask[2]) - 2'(own);
    assign factor_d[k] = emph_factor(own, n_other);
    assign chan_d[k]   = flags_i[FlagGray] ? avg : chan_i[k];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q   <= chan_d;
      factor_q <= factor_d;
    end
  end

  assign chan_o   = chan_q;
  assign factor_o = factor_q;

endmodule

[rtl/pta_emph_lane.sv]
// ----------------------------------------------------------------------------
// pta_emph_lane
// One color channel: multiply by the emphasis factor, divide by 1000 via
// reciprocal multiply, clamp. Two register stages.
// ----------------------------------------------------------------------------
module pta_emph_lane (
  input  logic                          clk_i,
  input  pta_pkg::lane_en_t             en_i,
  input  logic [pta_pkg::ChanW-1:0]     chan_i,
  input  logic [pta_pkg::FactorW-1:0]   factor_i,
  output logic [pta_pkg::ChanW-1:0]     chan_o
);
  import pta_pkg::*;

  localparam int unsigned ProdW = ChanW + FactorW;
  localparam int unsigned QuotW = ProdW + 20 - Div1000Shift;

  logic [ProdW-1:0]    prod_d, prod_q;
  logic [ProdW+19:0]   recip;
  logic [QuotW-1:0]    quot;
  logic [ChanW-1:0]    chan_d, chan_q;

  assign prod_d = chan_i * factor_i;
  assign recip  = prod_q * Div1000Mul;
  assign quot   = recip[Div1000Shift +: QuotW];
  assign chan_d = (quot > QuotW'(ChanMax)) ? ChanMax : quot[ChanW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.load_a) begin
      prod_q <= prod_d;
    end
    if (en_i.load_b) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

[rtl/pixel_tint_adjust_unit.sv]
// ----------------------------------------------------------------------------
// pixel_tint_adjust_unit
// ARGB pixel adjust: premultiply, brightness, grayscale, color emphasis.
// Throughput: one request per cycle while stall_i is low; each stage
// advances when it is empty or the stage after it advances, so bubbles
// are squeezed out.
// Reset: asynchronous, active low, clears the stage valid bits only.
// ----------------------------------------------------------------------------
module pixel_tint_adjust_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [pta_pkg::PixW-1:0]      argb_in_i,
  input  logic [pta_pkg::BrightW-1:0]   brightness_i,
  input  logic [pta_pkg::FlagW-1:0]     adjust_flags_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [pta_pkg::PixW-1:0]      argb_out_o
);
  import pta_pkg::*;

  logic [Stages-1:0]             vld_d, vld_q;
  logic [Stages-1:0]             ready;
  logic [Stages-1:0][ChanW-1:0]  alpha_q;
  logic [BrightW-1:0]            bright_q;
  logic [FlagW-1:0]              flags1_q, flags2_q;
  chan_vec_t                     src_chan, lane_chan, merge_chan, out_chan;
  factor_vec_t                   merge_factor;
  lane_en_t                      front_en, back_en;

  always_comb begin
    ready[Stages-1] = !vld_q[Stages-1] || !stall_i;
    for (int s = Stages - 2; s >= 0; s--) begin
      ready[s] = !vld_q[s] || ready[s+1];
    end
  end

  always_comb begin
    vld_d[0] = ready[0] ? valid_i : vld_q[0];
    for (int s = 1; s < Stages; s++) begin
      vld_d[s] = ready[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      alpha_q[0] <= argb_in_i[PixW-1 -: ChanW];
      bright_q   <= brightness_i;
      flags1_q   <= adjust_flags_i;
    end
    if (ready[1]) begin
      flags2_q <= flags1_q;
    end
    for (int s = 1; s < Stages; s++) begin
      if (ready[s]) begin
        alpha_q[s] <= alpha_q[s-1];
      end
    end
  end

  assign src_chan = argb_in_i[NumChan*ChanW-1:0];
  assign front_en = '{load_a: ready[0], load_b: ready[1]};
  assign back_en  = '{load_a: ready[3], load_b: ready[4]};

  for (genvar k = 0; k < NumChan; k++) begin : g_lane
    pta_chan_lane u_chan (
      .clk_i    (clk_i),
      .en_i     (front_en),
      .alpha_i  (argb_in_i[PixW-1 -: ChanW]),
      .chan_i   (src_chan[k]),
      .bright_i (bright_q),
      .chan_o   (lane_chan[k])
    );

    pta_emph_lane u_emph (
      .clk_i    (clk_i),
      .en_i     (back_en),
      .chan_i   (merge_chan[k]),
      .factor_i (merge_factor[k]),
      .chan_o   (out_chan[k])
    );
  end

  pta_gray_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (ready[2]),
    .chan_i   (lane_chan),
    .flags_i  (flags2_q),
    .chan_o   (merge_chan),
    .factor_o (merge_factor)
  );

  assign stall_o    = !ready[0];
  assign valid_o    = vld_q[Stages-1];
  assign argb_out_o = {alpha_q[Stages-1], out_chan};

endmodule

[rtl/pta_checker.sv]
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks for pixel_tint_adjust_unit, attached by bind.
// ----------------------------------------------------------------------------
module pta_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          stall_o,
  input  logic [pta_pkg::PixW-1:0]      argb_in_i,
  input  logic [pta_pkg::BrightW-1:0]   brightness_i,
  input  logic [pta_pkg::FlagW-1:0]     adjust_flags_i,
  input  logic                          valid_o,
  input  logic                          stall_i,
  input  logic [pta_pkg::PixW-1:0]      argb_out_o
);
  import pta_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable({argb_in_i, brightness_i, adjust_flags_i}))
    else $error("stalled request dropped or changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(argb_out_o))
    else $error("stalled result changed");

  // an open output side means every stage can advance
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while output side is open");

  // a request taken while the output side stays open comes out with alpha untouched
  a_alpha_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i
    |=> valid_o && (argb_out_o[PixW-1 -: ChanW] == $past(argb_in_i[PixW-1 -: ChanW], 5)))
    else $error("alpha or latency mismatch");

endmodule

bind pixel_tint_adjust_unit pta_checker u_pta_checker (.*);
